>>> design/b64e_pkg.sv
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam int CHARS_PER_JOB = 4;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] UPPER_BASE = 8'h41;
   localparam logic [7:0] LOWER_BASE = 8'h61;
   localparam logic [7:0] DIGIT_BASE = 8'h30;

   localparam logic [5:0] UPPER_END = 6'd26;
   localparam logic [5:0] LOWER_END = 6'd52;
   localparam logic [5:0] DIGIT_END = 6'd62;

   // position of the next byte within its three-byte group
   typedef enum logic [1:0] {
      PHASE_FIRST,
      PHASE_SECOND,
      PHASE_THIRD
   } phase_type;

   // characters produced by one request, emitted from index 0 up to last_idx
   typedef struct packed {
      logic [CHARS_PER_JOB-1:0][7:0] chars;
      logic [1:0]                    last_idx;
      logic                          eom;
   } job_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] v8;
      logic [7:0] c;
      v8 = {2'b00, v};
      if (v < UPPER_END) begin
         c = UPPER_BASE + v8;
      end else if (v < LOWER_END) begin
         c = LOWER_BASE + (v8 - {2'b00, UPPER_END});
      end else if (v < DIGIT_END) begin
         c = DIGIT_BASE + (v8 - {2'b00, LOWER_END});
      end else if (v == DIGIT_END) begin
         c = PLUS_CHAR;
      end else begin
         c = SLASH_CHAR;
      end
      return c;
   endfunction

endpackage

>>> design/b64e_req_if.sv
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       final_byte;

   modport source (output valid, output in_byte, output final_byte, input ready);
   modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

>>> design/b64e_rsp_if.sv
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_message;

   modport source (output valid, output out_char, output end_of_message, input ready);
   modport sink   (input valid, input out_char, input end_of_message, output ready);
endinterface

>>> design/base64_stream_encoder.sv
// an accepted request is written into a queue entry, then loaded into the back end's
//   list before its first character shows; one character per cycle goes out, set by
//   the back end's character counter, while the response side is ready and lists are
//   queued; a request yields 1, 2, 3 or 4 characters, and three message bytes give four
// reset: synchronous, active high; clears group phase, leftover bits, queue
//   pointers and the back end's valid flag
module base64_stream_encoder
   import b64e_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_ch,
   b64e_rsp_if.source rsp_ch
);

   // front to queue
   logic    push;
   job_type push_job;
   logic    q_full;

   // queue to back
   logic    pop;
   logic    q_empty;
   job_type q_head;

   // front end: tracks the position within the group and the spare bits,
   // turns each request into its list of characters
   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   // short queue of character lists, lets each side stall on its own
   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // back end: holds one list and hands out a character per cycle while the
   // response side is ready, refilling from the queue as the last one goes
   b64e_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

>>> design/b64e_front.sv
module b64e_front
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req,
   input  logic       q_full,
   output logic       push,
   output job_type    push_job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic [7:0] b;
   logic       fin;

   assign b        = req.in_byte;
   assign fin      = req.final_byte;
   // no request is taken while reset is held
   assign req.ready = !q_full && !reset;
   assign push     = req.valid && req.ready;

   // next state
   always_comb begin
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      if (push) begin
         unique case (phase_ff)
            PHASE_SECOND: begin
               if (fin) begin
                  phase_in    = PHASE_FIRST;
                  leftover_in = 4'd0;
               end else begin
                  phase_in    = PHASE_THIRD;
                  leftover_in = b[3:0];
               end
            end
            PHASE_THIRD: begin
               phase_in    = PHASE_FIRST;
               leftover_in = 4'd0;
            end
            default: begin
               if (fin) begin
                  phase_in    = PHASE_FIRST;
                  leftover_in = 4'd0;
               end else begin
                  phase_in    = PHASE_SECOND;
                  leftover_in = {2'b00, b[1:0]};
               end
            end
         endcase
      end
   end

   // characters for this byte
   always_comb begin
      push_job = '0;
      unique case (phase_ff)
         PHASE_SECOND: begin
            push_job.chars[0] = sextet_char({leftover_ff[1:0], b[7:4]});
            if (fin) begin
               push_job.chars[1] = sextet_char({b[3:0], 2'b00});
               push_job.chars[2] = PAD_CHAR;
               push_job.last_idx = 2'd2;
               push_job.eom      = 1'b1;
            end
         end
         PHASE_THIRD: begin
            push_job.chars[0] = sextet_char({leftover_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.last_idx = 2'd1;
            push_job.eom      = fin;
         end
         default: begin
            push_job.chars[0] = sextet_char(b[7:2]);
            if (fin) begin
               push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_job.chars[2] = PAD_CHAR;
               push_job.chars[3] = PAD_CHAR;
               push_job.last_idx = 2'd3;
               push_job.eom      = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         leftover_ff <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      push && fin |=> phase_ff == PHASE_FIRST && leftover_ff == 4'd0)
      else $error("final byte did not restart the group");

   a_first_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_FIRST |-> leftover_ff == 4'd0)
      else $error("leftover bits held at start of group");

   a_second_narrow: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_SECOND |-> leftover_ff[3:2] == 2'b00)
      else $error("more than two leftover bits after first byte");

endmodule

>>> design/b64e_queue.sv
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   job_type             entry_ff [Depth];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   assign full  = count_ff == CNT_W'(Depth);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(Depth - 1)) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(Depth))
      else $error("queue count beyond depth");

endmodule

>>> design/b64e_back.sv
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_head,
   output logic       pop,
   b64e_rsp_if.source rsp
);

   job_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       taken;
   logic       done;

   assign rsp.valid          = cur_valid_ff;
   assign rsp.out_char       = cur_ff.chars[idx_ff];
   assign rsp.end_of_message = cur_ff.eom && (idx_ff == cur_ff.last_idx);

   assign taken = cur_valid_ff && rsp.ready;
   assign done  = taken && (idx_ff == cur_ff.last_idx);
   assign pop   = !q_empty && (!cur_valid_ff || done);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = q_head;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule
